// ----- design/u8u16_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    typedef logic [2:0]  count_t;
    typedef logic [29:0] payload_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic        eos;
    } cp_item_t;

    // continuation counts set by the lead byte
    localparam count_t NEED_NONE  = 3'd0;
    localparam count_t NEED_ONE   = 3'd1;
    localparam count_t NEED_TWO   = 3'd2;
    localparam count_t NEED_THREE = 3'd3;
    localparam count_t NEED_FOUR  = 3'd4;
    localparam count_t NEED_FIVE  = 3'd5;

    // lead byte ranges
    localparam logic [7:0] LEAD_1B_MAX = 8'h7F;
    localparam logic [7:0] LEAD_2B_MAX = 8'hDF;
    localparam logic [7:0] LEAD_3B_MAX = 8'hEF;
    localparam logic [7:0] LEAD_4B_MAX = 8'hF7;
    localparam logic [7:0] LEAD_5B_MAX = 8'hFB;

    // lead byte bases
    localparam logic [31:0] BASE_2B = 32'h0000_00C0;
    localparam logic [31:0] BASE_3B = 32'h0000_00E0;
    localparam logic [31:0] BASE_4B = 32'h0000_00F0;
    localparam logic [31:0] BASE_5B = 32'h0000_00F8;

    localparam logic [31:0] BMP_MAX     = 32'h0000_FFFF;
    localparam logic [31:0] SUPP_OFFSET = 32'h0001_0000;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;

endpackage : u8u16_pkg
`default_nettype wire

// ----- design/u8u16_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel into the decoder: one UTF-8 byte and end-of-stream flag.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface : u8u16_in_if
`default_nettype wire

// ----- design/u8u16_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_out_if
// Unit channel out of the decoder: one UTF-16 unit with its flags.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] utf16_unit;
    logic        run_last;
    logic        stream_done;

    modport source (output valid, output utf16_unit, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input utf16_unit, input run_last, input stream_done,
                    output ready);
endinterface : u8u16_out_if
`default_nettype wire

// ----- design/u8u16_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_seq
// Sequence tracker: collects lead and continuation bytes and computes the
// code point when a sequence completes.
// ----------------------------------------------------------------------------
module u8u16_seq
    import u8u16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    u8u16_in_if.sink  utf8,
    output cp_item_t  cp_item,
    output logic      cp_valid,
    input  wire logic cp_ready
);

    logic [7:0] lead_reg,    lead_next;
    count_t     needed_reg,  needed_next;
    count_t     seen_reg,    seen_next;
    payload_t   accum_reg,   accum_next;

    logic        fire;
    logic [7:0]  b;
    logic        eos;
    count_t      seen_inc;
    payload_t    accum_shift;
    logic [31:0] lead_ext;
    logic [31:0] finish_cp;

    assign utf8.ready = cp_ready;
    assign fire       = utf8.valid && utf8.ready;
    assign b          = utf8.data_byte;
    assign eos        = utf8.end_of_stream;
    assign seen_inc   = seen_reg + 3'd1;
    assign accum_shift = {accum_reg[23:0], b[5:0]};
    assign lead_ext   = {24'd0, lead_reg};

    always_comb
    begin
        unique case (needed_reg)
            NEED_ONE:   finish_cp = ((lead_ext - BASE_2B) << 6)  + {2'd0, accum_shift};
            NEED_TWO:   finish_cp = ((lead_ext - BASE_3B) << 12) + {2'd0, accum_shift};
            NEED_THREE: finish_cp = ((lead_ext - BASE_4B) << 18) + {2'd0, accum_shift};
            NEED_FOUR:  finish_cp = ((lead_ext - BASE_5B) << 24) + {2'd0, accum_shift};
            default:    finish_cp = {1'b0, lead_reg[0], 30'd0} + {2'd0, accum_shift};
        endcase
    end

    always_comb
    begin
        lead_next   = lead_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        accum_next  = accum_reg;
        cp_valid    = 1'b0;
        cp_item.code_point = {24'd0, b};
        cp_item.eos        = eos;
        if (fire)
        begin
            if (needed_reg == NEED_NONE)
            begin
                if (b <= LEAD_1B_MAX)
                begin
                    cp_valid = 1'b1;
                end
                else
                begin
                    lead_next  = b;
                    seen_next  = NEED_NONE;
                    accum_next = '0;
                    if (b <= LEAD_2B_MAX)
                        needed_next = NEED_ONE;
                    else if (b <= LEAD_3B_MAX)
                        needed_next = NEED_TWO;
                    else if (b <= LEAD_4B_MAX)
                        needed_next = NEED_THREE;
                    else if (b <= LEAD_5B_MAX)
                        needed_next = NEED_FOUR;
                    else
                        needed_next = NEED_FIVE;
                    // lead byte that ends the stream is dropped
                    if (eos)
                    begin
                        lead_next   = '0;
                        needed_next = NEED_NONE;
                    end
                end
            end
            else if (seen_inc >= needed_reg)
            begin
                cp_valid           = 1'b1;
                cp_item.code_point = finish_cp;
                lead_next   = '0;
                needed_next = NEED_NONE;
                seen_next   = NEED_NONE;
                accum_next  = '0;
            end
            else if (eos)
            begin
                // incomplete sequence at end of stream
                lead_next   = '0;
                needed_next = NEED_NONE;
                seen_next   = NEED_NONE;
                accum_next  = '0;
            end
            else
            begin
                seen_next  = seen_inc;
                accum_next = accum_shift;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= '0;
            needed_reg <= NEED_NONE;
            seen_reg   <= NEED_NONE;
            accum_reg  <= '0;
        end
        else
        begin
            lead_reg   <= lead_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
            accum_reg  <= accum_next;
        end
    end

    a_seen_below_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (needed_reg != NEED_NONE) |-> (seen_reg < needed_reg))
        else $error("continuation count reached sequence length without completing");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (needed_reg == NEED_NONE) |-> (seen_reg == NEED_NONE && accum_reg == '0))
        else $error("idle tracker holds stale sequence state");

    a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eos) |=> (needed_reg == NEED_NONE))
        else $error("sequence left open after end of stream");

endmodule : u8u16_seq
`default_nettype wire

// ----- design/u8u16_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_emit
// Unit emitter: holds one completed code point and sends it as one UTF-16
// unit or as a surrogate pair through a registered output.
// ----------------------------------------------------------------------------
module u8u16_emit
    import u8u16_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cp_item_t  cp_item,
    input  wire logic      cp_valid,
    output logic           cp_ready,
    u8u16_out_if.source    utf16
);

    cp_item_t    item_reg;
    logic        held_reg,     held_next;
    logic        half_reg,     half_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] unit_reg,     unit_next;
    logic        run_last_reg, run_last_next;
    logic        done_reg,     done_next;

    logic        load;
    logic        is_pair;
    logic        consume;
    logic [31:0] offs;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;

    assign load    = !out_valid_reg || utf16.ready;
    assign is_pair = item_reg.code_point > BMP_MAX;
    assign offs    = item_reg.code_point - SUPP_OFFSET;
    assign hi_unit = offs[25:10] + HI_SURR;
    assign lo_unit = {6'd0, offs[9:0]} + LO_SURR;
    assign consume = held_reg && load && (!is_pair || half_reg);
    assign cp_ready = !held_reg || consume;

    always_comb
    begin
        held_next      = held_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        unit_next      = unit_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;
        if (load)
        begin
            out_valid_next = held_reg;
            if (held_reg)
            begin
                if (is_pair && !half_reg)
                begin
                    unit_next     = hi_unit;
                    run_last_next = 1'b0;
                    done_next     = 1'b0;
                    half_next     = 1'b1;
                end
                else
                begin
                    unit_next     = is_pair ? lo_unit : item_reg.code_point[15:0];
                    run_last_next = 1'b1;
                    done_next     = item_reg.eos;
                    half_next     = 1'b0;
                end
            end
        end
        if (cp_valid && cp_ready)
            held_next = 1'b1;
        else if (consume)
            held_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cp_valid && cp_ready)
            item_reg <= cp_item;
        unit_reg     <= unit_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
    end

    assign utf16.valid       = out_valid_reg;
    assign utf16.utf16_unit  = unit_reg;
    assign utf16.run_last    = run_last_reg;
    assign utf16.stream_done = done_reg;

    a_half_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (held_reg && is_pair))
        else $error("low surrogate pending without a held supplementary code point");

    a_high_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(half_reg) |-> (out_valid_reg && !run_last_reg && !done_reg))
        else $error("high surrogate not presented as first word of a pair");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> run_last_reg)
        else $error("stream end flagged on a word that is not last for its byte");

endmodule : u8u16_emit
`default_nettype wire

// ----- design/utf8_to_utf16_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming decoder from legacy UTF-8 (sequences up to six bytes) to UTF-16.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle while the unit emitter can accept a code
// point. A byte that completes a code point up to 0xFFFF gives one output
// word, and a code point above it gives a surrogate pair of output words.
// A completed code point is registered in the emitter's item register, and
// its words then pass through the emitter's single output register.
// Continuation bytes are not checked, stray lead bytes give wrapped values,
// and a sequence still open at end of stream is dropped without output.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8u16_in_if.sink    utf8,
    u8u16_out_if.source utf16
);

    cp_item_t cp_item;
    logic     cp_valid;
    logic     cp_ready;

    u8u16_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .utf8     (utf8),
        .cp_item  (cp_item),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready)
    );

    u8u16_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cp_item  (cp_item),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .utf16    (utf16)
    );

endmodule : utf8_to_utf16_decoder
`default_nettype wire
